### hw/rtl/scfs_pkg.sv
// shared types and constants of the square channel frame sequencer
`default_nettype none

package scfs_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_LENGTH  = 2'd2,
        REQ_NONE    = 2'd3
    } req_type_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_APU_ENABLE     = 3'd0,
        CFG_SWEEP_PACE     = 3'd1,
        CFG_SWEEP_SUBTRACT = 3'd2,
        CFG_SWEEP_SHIFT    = 3'd3,
        CFG_ENVELOPE_PACE  = 3'd4,
        CFG_ENVELOPE_UP    = 3'd5,
        CFG_LENGTH_ENABLE  = 3'd6,
        CFG_UNUSED         = 3'd7
    } cfg_index_t;

    localparam int PERIOD_W   = 11;
    localparam int VOLUME_W   = 4;
    localparam int LENGTH_W   = 6;
    localparam int PACE_W     = 3;
    localparam int CFG_DATA_W = 3;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    localparam logic [VOLUME_W-1:0] VOL_MAX = 4'hF;
    localparam logic [VOLUME_W-1:0] VOL_MIN = 4'h0;

endpackage

`default_nettype wire

### hw/rtl/square_channel_frame_sequencer.sv
// top level of the square channel frame sequencer
`default_nettype none

// Control half of a sweep square-wave channel, driven by a request stream.
// s_ channel: one request per beat. s_tuser gives the kind (tick, trigger,
// length write); s_tdata carries the new period, volume and length.
// m_ channel: one result per request with channel on flag, period and volume
// as they stand after that request.
// cfg port: cfg_wr_en, cfg_index and cfg_wdata write one control register a
// cycle; write only while no request is in flight.
// The accepting edge loads the result register, so the result is offered in
// the next cycle. Throughput: one request per cycle while the result side
// keeps m_tready high; divider, envelope, length and sweep state update together.
// Stall: while a result waits with m_tready low, s_tready is low; as soon as
// the result is taken a new request is accepted in the same cycle.
// Reset (aresetn low, synchronous): all dividers, counters and the channel
// state clear, the channel is off, apu_enable reads 1 and all other control
// registers 0; the output register is emptied.
module square_channel_frame_sequencer #(
    parameter int ENV_DIVIDE   = 8,
    parameter int LEN_DIVIDE   = 2,
    parameter int SWEEP_DIVIDE = 4,
    parameter int LENGTH_LIMIT = 64,
    parameter int PERIOD_LIMIT = 2048
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // cfg
    input  wire logic                            cfg_wr_en,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [scfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // new_period [10:0], new_volume [14:11], new_length [20:15], zero [23:21]
    input  wire logic [scfs_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]                      s_tuser,
    // result channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // channel_on [0], period [11:1], volume [15:12]
    output logic [scfs_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int ENV_W   = $clog2(ENV_DIVIDE + 1);
    localparam int LDIV_W  = $clog2(LEN_DIVIDE + 1);
    localparam int SDIV_W  = $clog2(SWEEP_DIVIDE + 1);
    localparam int LCNT_W  = $clog2(LENGTH_LIMIT + 1);
    localparam int LEN_W   = (LCNT_W > scfs_pkg::LENGTH_W) ? LCNT_W : scfs_pkg::LENGTH_W;
    localparam int PLIM_W  = $clog2(PERIOD_LIMIT);
    localparam int PER_W   = (PLIM_W > scfs_pkg::PERIOD_W) ? PLIM_W : scfs_pkg::PERIOD_W;
    localparam int PACE_W  = scfs_pkg::PACE_W;
    localparam int VOL_W   = scfs_pkg::VOLUME_W;

    localparam logic [ENV_W-1:0]  ENV_TERM   = ENV_W'(ENV_DIVIDE);
    localparam logic [LDIV_W-1:0] LEN_TERM   = LDIV_W'(LEN_DIVIDE);
    localparam logic [SDIV_W-1:0] SWEEP_TERM = SDIV_W'(SWEEP_DIVIDE);
    localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(LENGTH_LIMIT);
    localparam logic [PER_W:0]    PER_MAX    = (PER_W + 1)'(PERIOD_LIMIT - 1);

    // control registers
    logic              apu_enable_reg;
    logic [PACE_W-1:0] sweep_pace_reg;
    logic              sweep_subtract_reg;
    logic [2:0]        sweep_shift_reg;
    logic [PACE_W-1:0] envelope_pace_reg;
    logic              envelope_up_reg;
    logic              length_enable_reg;

    // channel state
    logic [ENV_W-1:0]    env_div_reg,      env_div_next;
    logic [LDIV_W-1:0]   len_div_reg,      len_div_next;
    logic [SDIV_W-1:0]   sweep_div_reg,    sweep_div_next;
    logic [PACE_W-1:0]   env_steps_reg,    env_steps_next;
    logic [PACE_W-1:0]   sweep_steps_reg,  sweep_steps_next;
    logic [LEN_W-1:0]    len_count_reg,    len_count_next;
    logic [scfs_pkg::LENGTH_W-1:0] len_reload_reg, len_reload_next;
    logic                len_pending_reg,  len_pending_next;
    logic                active_reg,       active_next;
    logic [PER_W-1:0]    period_reg,       period_next;
    logic [VOL_W-1:0]    volume_reg,       volume_next;

    logic                              m_tvalid_reg;
    logic [scfs_pkg::M_DATA_W-1:0]     m_tdata_reg;

    logic                        s_fire;
    scfs_pkg::req_type_t         req;
    logic [scfs_pkg::PERIOD_W-1:0] in_period;
    logic [VOL_W-1:0]            in_volume;
    logic [scfs_pkg::LENGTH_W-1:0] in_length;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign req       = scfs_pkg::req_type_t'(s_tuser);
    assign in_period = s_tdata[scfs_pkg::PERIOD_W-1:0];
    assign in_volume = s_tdata[scfs_pkg::PERIOD_W +: VOL_W];
    assign in_length = s_tdata[scfs_pkg::PERIOD_W + VOL_W +: scfs_pkg::LENGTH_W];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // next channel state for the request on the input
    always_comb begin
        logic [ENV_W-1:0]  env_inc;
        logic [LDIV_W-1:0] len_inc;
        logic [SDIV_W-1:0] sweep_inc;
        logic [PACE_W-1:0] steps_inc;
        logic [PER_W-1:0]  delta;
        logic [PER_W:0]    sum;

        env_div_next     = env_div_reg;
        len_div_next     = len_div_reg;
        sweep_div_next   = sweep_div_reg;
        env_steps_next   = env_steps_reg;
        sweep_steps_next = sweep_steps_reg;
        len_count_next   = len_count_reg;
        len_reload_next  = len_reload_reg;
        len_pending_next = len_pending_reg;
        active_next      = active_reg;
        period_next      = period_reg;
        volume_next      = volume_reg;

        env_inc   = env_div_reg + 1'b1;
        len_inc   = len_div_reg + 1'b1;
        sweep_inc = sweep_div_reg + 1'b1;
        steps_inc = '0;
        delta     = period_reg >> sweep_shift_reg;
        sum       = {1'b0, period_reg} + {1'b0, delta};

        unique case (req)
            scfs_pkg::REQ_TICK: begin
                if (apu_enable_reg) begin
                    env_div_next   = env_inc;
                    len_div_next   = len_inc;
                    sweep_div_next = sweep_inc;

                    // envelope first
                    if (env_inc >= ENV_TERM) begin
                        env_div_next = '0;
                        if (active_reg && envelope_pace_reg != '0) begin
                            steps_inc = env_steps_reg + 1'b1;
                            env_steps_next = steps_inc;
                            if (steps_inc >= envelope_pace_reg) begin
                                env_steps_next = '0;
                                if (envelope_up_reg) begin
                                    if (volume_reg < scfs_pkg::VOL_MAX) begin
                                        volume_next = volume_reg + 1'b1;
                                    end
                                end else if (volume_reg > scfs_pkg::VOL_MIN) begin
                                    volume_next = volume_reg - 1'b1;
                                end
                            end
                        end
                    end

                    // then length, which may switch the channel off
                    if (len_inc >= LEN_TERM) begin
                        len_div_next = '0;
                        if (active_reg && length_enable_reg) begin
                            if (len_pending_reg) begin
                                len_count_next   = LEN_W'(len_reload_reg);
                                len_pending_next = 1'b0;
                            end
                            if (len_count_next < LEN_LIMIT) begin
                                len_count_next = len_count_next + 1'b1;
                            end
                            if (len_count_next >= LEN_LIMIT) begin
                                active_next = 1'b0;
                            end
                        end
                    end

                    // sweep last, seeing the channel state after length
                    if (sweep_inc >= SWEEP_TERM) begin
                        sweep_div_next = '0;
                        if (active_next && sweep_pace_reg != '0) begin
                            steps_inc = sweep_steps_reg + 1'b1;
                            sweep_steps_next = steps_inc;
                            if (steps_inc >= sweep_pace_reg) begin
                                sweep_steps_next = '0;
                                if (sweep_subtract_reg) begin
                                    // underflow below one leaves the period alone
                                    if (delta < period_reg) begin
                                        period_next = period_reg - delta;
                                    end
                                end else if (sum > PER_MAX) begin
                                    active_next = 1'b0;
                                end else begin
                                    period_next = sum[PER_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            scfs_pkg::REQ_TRIGGER: begin
                period_next = PER_W'(in_period);
                volume_next = in_volume;
                active_next = 1'b1;
            end
            scfs_pkg::REQ_LENGTH: begin
                len_reload_next  = in_length;
                len_pending_next = 1'b1;
            end
            scfs_pkg::REQ_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            apu_enable_reg     <= 1'b1;
            sweep_pace_reg     <= '0;
            sweep_subtract_reg <= 1'b0;
            sweep_shift_reg    <= '0;
            envelope_pace_reg  <= '0;
            envelope_up_reg    <= 1'b0;
            length_enable_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (scfs_pkg::cfg_index_t'(cfg_index))
                scfs_pkg::CFG_APU_ENABLE:     apu_enable_reg     <= cfg_wdata[0];
                scfs_pkg::CFG_SWEEP_PACE:     sweep_pace_reg     <= cfg_wdata[PACE_W-1:0];
                scfs_pkg::CFG_SWEEP_SUBTRACT: sweep_subtract_reg <= cfg_wdata[0];
                scfs_pkg::CFG_SWEEP_SHIFT:    sweep_shift_reg    <= cfg_wdata[2:0];
                scfs_pkg::CFG_ENVELOPE_PACE:  envelope_pace_reg  <= cfg_wdata[PACE_W-1:0];
                scfs_pkg::CFG_ENVELOPE_UP:    envelope_up_reg    <= cfg_wdata[0];
                scfs_pkg::CFG_LENGTH_ENABLE:  length_enable_reg  <= cfg_wdata[0];
                scfs_pkg::CFG_UNUSED: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_div_reg     <= '0;
            len_div_reg     <= '0;
            sweep_div_reg   <= '0;
            env_steps_reg   <= '0;
            sweep_steps_reg <= '0;
            len_count_reg   <= '0;
            len_reload_reg  <= '0;
            len_pending_reg <= 1'b0;
            active_reg      <= 1'b0;
            period_reg      <= '0;
            volume_reg      <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                env_div_reg     <= env_div_next;
                len_div_reg     <= len_div_next;
                sweep_div_reg   <= sweep_div_next;
                env_steps_reg   <= env_steps_next;
                sweep_steps_reg <= sweep_steps_next;
                len_count_reg   <= len_count_next;
                len_reload_reg  <= len_reload_next;
                len_pending_reg <= len_pending_next;
                active_reg      <= active_next;
                period_reg      <= period_next;
                volume_reg      <= volume_next;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= {volume_next, period_next[scfs_pkg::PERIOD_W-1:0], active_next};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/scfs_checker.sv
// port-level checks of the square channel frame sequencer, bound to the top level
`default_nettype none

module scfs_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [scfs_pkg::S_DATA_W-1:0]   s_tdata,
    input wire logic [1:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [scfs_pkg::M_DATA_W-1:0]   m_tdata
);

    logic s_fire;
    logic trig_fire;

    assign s_fire    = s_tvalid && s_tready;
    assign trig_fire = s_fire && (s_tuser == scfs_pkg::REQ_TRIGGER);

    // every accepted request leaves a result in the output register
    a_request_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid
    ) else $error("accepted request produced no result");

    // a waiting result blocks new requests
    a_stall_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready
    ) else $error("request accepted while a result was stalled");

    // trigger loads period and volume and switches the channel on
    a_trigger_loads: assert property (
        @(posedge aclk) disable iff (!aresetn)
        trig_fire |=> (m_tdata[0] == 1'b1)
            && (m_tdata[11:1] == $past(s_tdata[10:0]))
            && (m_tdata[15:12] == $past(s_tdata[14:11]))
    ) else $error("trigger result does not match request");

    // a stalled result keeps its contents
    a_stall_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))
    ) else $error("stalled result changed");

endmodule

bind square_channel_frame_sequencer scfs_checker u_scfs_checker (.*);

`default_nettype wire

### test/scfs_channel_checker.sv
// result checker for the square channel frame sequencer: tracks channel state and compares
`timescale 1ns / 1ps

module scfs_channel_checker #(
    parameter int ENV_DIVIDE   = 8,
    parameter int LEN_DIVIDE   = 2,
    parameter int SWEEP_DIVIDE = 4,
    parameter int LENGTH_LIMIT = 64,
    parameter int PERIOD_LIMIT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  scfs_pkg::cfg_index_t                cfg_index,
    input  logic [scfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // new_period [10:0], new_volume [14:11], new_length [20:15], zero [23:21]
    input  logic [scfs_pkg::S_DATA_W-1:0]       s_tdata,
    // req_type [1:0]
    input  scfs_pkg::req_type_t                 s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // channel_on [0], period [11:1], volume [15:12]
    input  logic [scfs_pkg::M_DATA_W-1:0]       m_tdata,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  checked
);
    import scfs_pkg::*;

    typedef struct packed {
        logic                on;
        logic [PERIOD_W-1:0] period;
        logic [VOLUME_W-1:0] volume;
    } chan_state_t;

    // control registers
    logic                apu_en;
    logic [PACE_W-1:0]   sweep_pace;
    logic                sweep_sub;
    logic [2:0]          sweep_shift;
    logic [PACE_W-1:0]   env_pace;
    logic                env_up;
    logic                len_en;

    // sequencer state
    logic [3:0]          env_div;
    logic [1:0]          len_div;
    logic [2:0]          sweep_div;
    logic [2:0]          env_steps;
    logic [2:0]          sweep_steps;
    logic [6:0]          len_count;
    logic [LENGTH_W-1:0] len_reload;
    logic                len_pending;
    logic                chan_on;
    logic [PERIOD_W-1:0] chan_period;
    logic [VOLUME_W-1:0] chan_volume;

    chan_state_t         expected_states[$];
    chan_state_t         want;

    task automatic advance_channel(input req_type_t kind, input logic [S_DATA_W-1:0] data);
        logic [PERIOD_W-1:0] delta;
        logic [PERIOD_W:0]   sum;
        case (kind)
            REQ_TICK: begin
                if (apu_en) begin
                    env_div++;
                    len_div++;
                    sweep_div++;
                    // envelope, then length, then sweep
                    if (env_div >= ENV_DIVIDE) begin
                        env_div = '0;
                        if (chan_on && env_pace != 0) begin
                            env_steps++;
                            if (env_steps >= env_pace) begin
                                env_steps = '0;
                                if (env_up) begin
                                    if (chan_volume < VOL_MAX) chan_volume++;
                                end else if (chan_volume > VOL_MIN) begin
                                    chan_volume--;
                                end
                            end
                        end
                    end
                    if (len_div >= LEN_DIVIDE) begin
                        len_div = '0;
                        if (chan_on && len_en) begin
                            if (len_pending) begin
                                len_count   = {1'b0, len_reload};
                                len_pending = 1'b0;
                            end
                            if (len_count < LENGTH_LIMIT) len_count++;
                            if (len_count >= LENGTH_LIMIT) chan_on = 1'b0;
                        end
                    end
                    if (sweep_div >= SWEEP_DIVIDE) begin
                        sweep_div = '0;
                        if (chan_on && sweep_pace != 0) begin
                            sweep_steps++;
                            if (sweep_steps >= sweep_pace) begin
                                sweep_steps = '0;
                                delta = chan_period >> sweep_shift;
                                if (sweep_sub) begin
                                    // a period that would drop below 1 is kept
                                    if (delta < chan_period) chan_period = chan_period - delta;
                                end else begin
                                    sum = {1'b0, chan_period} + delta;
                                    if (sum > PERIOD_LIMIT - 1) chan_on = 1'b0;
                                    else chan_period = sum[PERIOD_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            REQ_TRIGGER: begin
                chan_period = data[PERIOD_W-1:0];
                chan_volume = data[PERIOD_W +: VOLUME_W];
                chan_on     = 1'b1;
            end
            REQ_LENGTH: begin
                len_reload  = data[PERIOD_W+VOLUME_W +: LENGTH_W];
                len_pending = 1'b1;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            apu_en      = 1'b1;
            sweep_pace  = '0;
            sweep_sub   = 1'b0;
            sweep_shift = '0;
            env_pace    = '0;
            env_up      = 1'b0;
            len_en      = 1'b0;
            env_div     = '0;
            len_div     = '0;
            sweep_div   = '0;
            env_steps   = '0;
            sweep_steps = '0;
            len_count   = '0;
            len_reload  = '0;
            len_pending = 1'b0;
            chan_on     = 1'b0;
            chan_period = '0;
            chan_volume = '0;
            expected_states.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_APU_ENABLE:     apu_en      = cfg_wdata[0];
                    CFG_SWEEP_PACE:     sweep_pace  = cfg_wdata[PACE_W-1:0];
                    CFG_SWEEP_SUBTRACT: sweep_sub   = cfg_wdata[0];
                    CFG_SWEEP_SHIFT:    sweep_shift = cfg_wdata[2:0];
                    CFG_ENVELOPE_PACE:  env_pace    = cfg_wdata[PACE_W-1:0];
                    CFG_ENVELOPE_UP:    env_up      = cfg_wdata[0];
                    CFG_LENGTH_ENABLE:  len_en      = cfg_wdata[0];
                    default: ;
                endcase
            end
            // compare before queuing, so a same-edge request cannot mask a stray result
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_states.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end else begin
                    want = expected_states.pop_front();
                    check_field("channel_on", want.on, m_tdata[0]);
                    check_field("period", want.period, m_tdata[PERIOD_W:1]);
                    check_field("volume", want.volume, m_tdata[PERIOD_W+1 +: VOLUME_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_channel(s_tuser, s_tdata);
                expected_states.push_back({chan_on, chan_period, chan_volume});
            end
        end
        pending = expected_states.size();
    end

endmodule

### test/square_channel_frame_sequencer_test.sv
// top of the square channel frame sequencer testbench: clock, reset, requests and verdict
`timescale 1ns / 1ps

module square_channel_frame_sequencer_test;
    import scfs_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 86;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_APU_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    req_type_t             s_tuser   = REQ_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    int fail_count, chk_pending, chk_checked;
    int src_idle   = 0;
    int sink_stall = 0;
    int rx_hold    = 0;
    int n_kind [4] = '{0, 0, 0, 0};
    int n_settings = 0;
    int idle_run   = 0;

    square_channel_frame_sequencer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    scfs_channel_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (chk_pending),
        .checked    (chk_checked)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall);
            end
        end
    end

    // watchdog on stretches with no handshake at all
    initial begin
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
            else idle_run++;
        end
        $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_request(input req_type_t kind, input logic [PERIOD_W-1:0] per,
                                input logic [VOLUME_W-1:0] vol, input logic [LENGTH_W-1:0] len);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, len, vol, per};
        do @(posedge aclk); while (!s_tready);
        n_kind[kind]++;
    endtask

    task automatic send_random_request();
        req_type_t           kind;
        logic [PERIOD_W-1:0] per;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)      kind = REQ_TICK;
        else if (pick < 82) kind = REQ_TRIGGER;
        else if (pick < 94) kind = REQ_LENGTH;
        else                kind = REQ_NONE;
        case ($urandom_range(0, 3))
            0:       per = $urandom_range(0, 15);
            1:       per = $urandom_range(1792, 2047);
            default: per = $urandom_range(0, 2047);
        endcase
        // lengths near the limit so the counter runs out often
        send_request(kind, per, $urandom_range(0, 15),
                     $urandom_range(0, 1) ? $urandom_range(48, 63) : $urandom_range(0, 63));
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // waits for the block to drain, then rewrites every register
    task automatic load_config(input logic [2:0] apu, sw_pace, sw_sub, sw_shift,
                               env_pace, env_up, len_en);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (chk_pending == 0);
        @(posedge aclk);
        write_reg(CFG_APU_ENABLE, apu);
        write_reg(CFG_SWEEP_PACE, sw_pace);
        write_reg(CFG_SWEEP_SUBTRACT, sw_sub);
        write_reg(CFG_SWEEP_SHIFT, sw_shift);
        write_reg(CFG_ENVELOPE_PACE, env_pace);
        write_reg(CFG_ENVELOPE_UP, env_up);
        write_reg(CFG_LENGTH_ENABLE, len_en);
        write_reg(CFG_UNUSED, $urandom_range(0, 7));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fast envelope up, sweep adding with no shift, length on
        load_config(1, 1, 0, 0, 1, 1, 1);
        send_request(REQ_NONE, 11'h7FF, 4'hF, 6'h3F);
        send_request(REQ_LENGTH, 11'h000, 4'h0, 6'd62);
        send_request(REQ_TRIGGER, 11'h7FF, 4'hF, 6'h00);
        repeat (8) send_request(REQ_TICK, $urandom_range(0, 2047), $urandom_range(0, 15),
                                $urandom_range(0, 63));
        send_request(REQ_TRIGGER, 11'd1024, 4'h0, 6'h00);
        repeat (4) send_request(REQ_TICK, 11'h000, 4'h0, 6'h00);

        // directed: sweep subtracting down to the floor, envelope falling
        load_config(1, 1, 1, 0, 1, 0, 1);
        send_request(REQ_TRIGGER, 11'd1, 4'd1, 6'h00);
        repeat (8) send_request(REQ_TICK, 11'h7FF, 4'hF, 6'h3F);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       load_config(1, 7, 1, 7, 7, 1, 1);
                1:       load_config(0, 0, 0, 0, 0, 0, 0);
                2:       load_config(1, 1, 0, 0, 1, 0, 1);
                3:       load_config(1, 2, 1, 1, 3, 1, 0);
                default: load_config($urandom_range(0, 9) != 0, $urandom_range(0, 7),
                                     $urandom_range(0, 1), $urandom_range(0, 7),
                                     $urandom_range(0, 7), $urandom_range(0, 1),
                                     $urandom_range(0, 1));
            endcase
            case (ph % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 82; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 82; end
                default: begin src_idle = 9;  sink_stall = 9;  end
            endcase
            // long hold-off while requests keep coming, to back up the input
            if (ph == 0) rx_hold = 300;
            repeat (PHASE_ITEMS) send_random_request();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (chk_pending == 0);
        repeat (4) @(posedge aclk);

        $display("sent %0d requests: %0d ticks, %0d triggers, %0d length writes, %0d unused",
                 n_kind[REQ_TICK] + n_kind[REQ_TRIGGER] + n_kind[REQ_LENGTH] + n_kind[REQ_NONE],
                 n_kind[REQ_TICK], n_kind[REQ_TRIGGER], n_kind[REQ_LENGTH], n_kind[REQ_NONE]);
        $display("compared %0d results across %0d register settings", chk_checked, n_settings);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
